### rtl/trm_pkg.sv
// Package for the token repetition monitor: commands, register indexes, config type.
`default_nettype none
package trm_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2
  } trm_cmd_e;

  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 17;
  localparam int OutBits     = 16;

  localparam logic [CfgIdxBits-1:0] CFG_MIN_UNIQUE = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_FREQ   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_RUN    = 2'd2;
  localparam logic [CfgIdxBits-1:0] CFG_MIN_TOKENS = 2'd3;

  localparam logic [16:0] ONE_Q16           = 17'h10000;
  localparam logic [16:0] MAX_FREQ_RESET    = 17'h10000;
  localparam logic [15:0] MIN_TOKENS_RESET  = 16'd16;

  typedef struct packed {
    logic [16:0] min_unique_ratio;
    logic [16:0] top_ratio_max;
    logic [15:0] max_run_limit;
    logic [15:0] min_tokens_for_checks;
  } trm_cfg_t;

endpackage
`default_nettype wire

### rtl/trm_if.sv
// Request and result channel interfaces of the token repetition monitor.
`default_nettype none
interface trm_in_if #(
  parameter int TOKEN_BITS = 17
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic [TOKEN_BITS-1:0] token_id;

  modport source(output valid, output cmd, output token_id, input ready);
  modport sink(input valid, input cmd, input token_id, output ready);
endinterface

interface trm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] total_tokens;
  logic [15:0] distinct_tokens;
  logic [15:0] top_count;
  logic [15:0] longest_run;
  logic        no_tokens;
  logic        low_unique;
  logic        high_freq;
  logic        long_run;
  logic        all_ok;

  modport source(output valid, output total_tokens, output distinct_tokens, output top_count,
                 output longest_run, output no_tokens, output low_unique, output high_freq,
                 output long_run, output all_ok, input ready);
  modport sink(input valid, input total_tokens, input distinct_tokens, input top_count,
               input longest_run, input no_tokens, input low_unique, input high_freq,
               input long_run, input all_ok, output ready);
endinterface
`default_nettype wire

### rtl/trm_count_mem.sv
// Per-token count memory: one write port, one read port with registered data.
`default_nettype none
module trm_count_mem #(
  parameter int TOKEN_BITS = 17,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rd_en_i,
  input  wire logic [TOKEN_BITS-1:0] rd_addr_i,
  output      logic [COUNT_BITS-1:0] rd_data_o,
  input  wire logic                  wr_en_i,
  input  wire logic [TOKEN_BITS-1:0] wr_addr_i,
  input  wire logic [COUNT_BITS-1:0] wr_data_i
);
  localparam int Depth = 1 << TOKEN_BITS;

  logic [COUNT_BITS-1:0] mem_q [Depth];
  logic [COUNT_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule
`default_nettype wire

### rtl/trm_stats.sv
// Count update with write-back forwarding, and the running statistics registers.
`default_nettype none
module trm_stats #(
  parameter int TOKEN_BITS = 17,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic                  clear_i,
  input  wire logic [TOKEN_BITS-1:0] tok_i,
  input  wire logic [COUNT_BITS-1:0] rd_data_i,
  output      logic                  wr_en_o,
  output      logic [TOKEN_BITS-1:0] wr_addr_o,
  output      logic [COUNT_BITS-1:0] wr_data_o,
  output      logic [COUNT_BITS-1:0] total_o,
  output      logic [COUNT_BITS-1:0] distinct_o,
  output      logic [COUNT_BITS-1:0] top_o,
  output      logic [COUNT_BITS-1:0] best_run_o
);
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  logic                  fwd_valid_q;
  logic [TOKEN_BITS-1:0] fwd_tok_q;
  logic [COUNT_BITS-1:0] fwd_cnt_q;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] distinct_q, distinct_d;
  logic [COUNT_BITS-1:0] top_q, top_d;
  logic [COUNT_BITS-1:0] run_q, run_d;
  logic [COUNT_BITS-1:0] best_q, best_d;
  logic [TOKEN_BITS-1:0] prev_q, prev_d;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_new;

  assign cnt_cur = (fwd_valid_q && fwd_tok_q == tok_i) ? fwd_cnt_q : rd_data_i;
  assign cnt_new = sat_inc(cnt_cur);

  always_comb begin
    total_d    = total_q;
    distinct_d = distinct_q;
    top_d      = top_q;
    run_d      = run_q;
    best_d     = best_q;
    prev_d     = prev_q;
    if (clear_i) begin
      total_d    = '0;
      distinct_d = '0;
      top_d      = '0;
      run_d      = '0;
      best_d     = '0;
      prev_d     = '0;
    end else if (push_i) begin
      if (cnt_cur == '0) begin
        distinct_d = sat_inc(distinct_q);
      end
      if (cnt_new > top_q) begin
        top_d = cnt_new;
      end
      if (total_q != '0 && tok_i == prev_q) begin
        run_d = sat_inc(run_q);
      end else begin
        run_d = COUNT_BITS'(1);
      end
      if (run_d > best_q) begin
        best_d = run_d;
      end
      prev_d  = tok_i;
      total_d = sat_inc(total_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      distinct_q  <= '0;
      top_q       <= '0;
      run_q       <= '0;
      best_q      <= '0;
      prev_q      <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      distinct_q  <= distinct_d;
      top_q       <= top_d;
      run_q       <= run_d;
      best_q      <= best_d;
      prev_q      <= prev_d;
      fwd_valid_q <= push_i && !clear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fwd_tok_q <= tok_i;
      fwd_cnt_q <= cnt_new;
    end
  end

  assign wr_en_o    = push_i;
  assign wr_addr_o  = tok_i;
  assign wr_data_o  = cnt_new;
  assign total_o    = total_q;
  assign distinct_o = distinct_q;
  assign top_o      = top_q;
  assign best_run_o = best_q;
endmodule
`default_nettype wire

### rtl/trm_report.sv
// Ratio and run checks, and the result output register.
`default_nettype none
module trm_report #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  report_i,
  output      logic                  full_o,
  input  wire trm_pkg::trm_cfg_t     cfg_i,
  input  wire logic [COUNT_BITS-1:0] total_i,
  input  wire logic [COUNT_BITS-1:0] distinct_i,
  input  wire logic [COUNT_BITS-1:0] top_i,
  input  wire logic [COUNT_BITS-1:0] best_run_i,
  trm_out_if.source                  out_o
);
  import trm_pkg::*;

  localparam int WideW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int ProdW = COUNT_BITS + 17;

  function automatic logic [OutBits-1:0] clamp16(input logic [COUNT_BITS-1:0] v);
    logic [WideW-1:0] ext;
    ext = WideW'(v);
    clamp16 = (ext > WideW'(16'hFFFF)) ? 16'hFFFF : ext[OutBits-1:0];
  endfunction

  logic             zero_f, low_f, high_f, run_f, checks_on;
  logic [ProdW-1:0] uniq_lhs, uniq_rhs, freq_lhs, freq_rhs;
  logic             load;

  logic             valid_q;
  logic [15:0]      total_q, distinct_q, top_q, run_q;
  logic             zero_q, low_q, high_q, long_q, ok_q;

  assign uniq_lhs = ProdW'(distinct_i) << 16;
  assign uniq_rhs = ProdW'(cfg_i.min_unique_ratio) * ProdW'(total_i);
  assign freq_lhs = ProdW'(top_i) << 16;
  assign freq_rhs = ProdW'(cfg_i.top_ratio_max) * ProdW'(total_i);

  always_comb begin
    zero_f    = (total_i == '0);
    checks_on = WideW'(total_i) >= WideW'(cfg_i.min_tokens_for_checks);
    low_f     = 1'b0;
    high_f    = 1'b0;
    run_f     = 1'b0;
    if (checks_on) begin
      if (cfg_i.min_unique_ratio != '0) begin
        low_f = zero_f ? (cfg_i.min_unique_ratio > ONE_Q16) : (uniq_lhs < uniq_rhs);
      end
      if (cfg_i.top_ratio_max < ONE_Q16 && !zero_f) begin
        high_f = freq_lhs > freq_rhs;
      end
      if (cfg_i.max_run_limit != '0) begin
        run_f = WideW'(best_run_i) > WideW'(cfg_i.max_run_limit);
      end
    end
  end

  assign full_o = valid_q && !out_o.ready;
  assign load   = report_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      total_q    <= clamp16(total_i);
      distinct_q <= clamp16(distinct_i);
      top_q      <= clamp16(top_i);
      run_q      <= clamp16(best_run_i);
      zero_q     <= zero_f;
      low_q      <= low_f;
      high_q     <= high_f;
      long_q     <= run_f;
      ok_q       <= !(zero_f || low_f || high_f || run_f);
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.total_tokens    = total_q;
  assign out_o.distinct_tokens = distinct_q;
  assign out_o.top_count       = top_q;
  assign out_o.longest_run     = run_q;
  assign out_o.no_tokens       = zero_q;
  assign out_o.low_unique      = low_q;
  assign out_o.high_freq       = high_q;
  assign out_o.long_run        = long_q;
  assign out_o.all_ok          = ok_q;
endmodule
`default_nettype wire

### rtl/token_repetition_monitor_top.sv
// Top level of the token repetition monitor.
// One request per cycle while ready is high; a report goes through s1, then the result register.
// A report that finds the previous result still waiting holds the input until it is taken.
// A push reads the count memory at accept and writes back in the following cycle, with forwarding.
// A clear sweeps the count memory from entry zero: one memory entry is zeroed per cycle.
// After reset the same sweep runs over all 2**TOKEN_BITS entries before requests are accepted.
`default_nettype none
module token_repetition_monitor_top #(
  parameter int TOKEN_BITS = 17,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  trm_in_if.sink                                   in_i,
  trm_out_if.source                                out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [trm_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  wire logic [trm_pkg::CfgDataBits-1:0]     cfg_data_i
);
  import trm_pkg::*;

  trm_cfg_t cfg_q;

  logic                  s1_valid_q;
  logic [1:0]            s1_cmd_q;
  logic [TOKEN_BITS-1:0] s1_tok_q;
  logic                  sweep_q;
  logic [TOKEN_BITS-1:0] sweep_ptr_q;

  logic                  accept, stall, s1_push, s1_report, s1_clear, rep_full;
  logic                  st_wr_en;
  logic [TOKEN_BITS-1:0] st_wr_addr;
  logic [COUNT_BITS-1:0] st_wr_data, rd_data;
  logic [COUNT_BITS-1:0] total, distinct, top, best_run;

  assign s1_push   = s1_valid_q && (s1_cmd_q == CMD_PUSH);
  assign s1_report = s1_valid_q && (s1_cmd_q == CMD_REPORT);
  assign s1_clear  = s1_valid_q && (s1_cmd_q == CMD_CLEAR);
  assign stall     = s1_report && rep_full;
  assign in_i.ready = !sweep_q && !s1_clear && !stall;
  assign accept    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_unique_ratio      <= '0;
      cfg_q.top_ratio_max         <= MAX_FREQ_RESET;
      cfg_q.max_run_limit         <= '0;
      cfg_q.min_tokens_for_checks <= MIN_TOKENS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_UNIQUE: cfg_q.min_unique_ratio      <= cfg_data_i;
        CFG_MAX_FREQ:   cfg_q.top_ratio_max         <= cfg_data_i;
        CFG_MAX_RUN:    cfg_q.max_run_limit         <= cfg_data_i[15:0];
        CFG_MIN_TOKENS: cfg_q.min_tokens_for_checks <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= in_i.cmd;
      s1_tok_q <= in_i.token_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_ptr_q <= '0;
    end else if (s1_clear) begin
      sweep_q     <= 1'b1;
      sweep_ptr_q <= '0;
    end else if (sweep_q) begin
      if (&sweep_ptr_q) begin
        sweep_q <= 1'b0;
      end
      sweep_ptr_q <= sweep_ptr_q + TOKEN_BITS'(1);
    end
  end

  trm_count_mem #(
    .TOKEN_BITS(TOKEN_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_i.token_id),
    .rd_data_o (rd_data),
    .wr_en_i   (sweep_q || st_wr_en),
    .wr_addr_i (sweep_q ? sweep_ptr_q : st_wr_addr),
    .wr_data_i (sweep_q ? '0 : st_wr_data)
  );

  trm_stats #(
    .TOKEN_BITS(TOKEN_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_push),
    .clear_i    (s1_clear),
    .tok_i      (s1_tok_q),
    .rd_data_i  (rd_data),
    .wr_en_o    (st_wr_en),
    .wr_addr_o  (st_wr_addr),
    .wr_data_o  (st_wr_data),
    .total_o    (total),
    .distinct_o (distinct),
    .top_o      (top),
    .best_run_o (best_run)
  );

  trm_report #(
    .COUNT_BITS(COUNT_BITS)
  ) u_report (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .report_i   (s1_report),
    .full_o     (rep_full),
    .cfg_i      (cfg_q),
    .total_i    (total),
    .distinct_i (distinct),
    .top_i      (top),
    .best_run_i (best_run),
    .out_o      (out_o)
  );
endmodule
`default_nettype wire

### verif/trm_stats_checker.sv
// Checker for the token repetition monitor: tracks token statistics and compares every report.
`default_nettype none
module trm_stats_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  trm_in_if                                   req_mon,
  trm_out_if                                  rsp_mon,
  input  wire logic                           cfg_we_i,
  input  wire logic [trm_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [trm_pkg::CfgDataBits-1:0] cfg_data_i,
  output int unsigned                         outstanding_o,
  output int unsigned                         mismatches_o
);
  import trm_pkg::*;

  localparam int          TokenBits  = 17;
  localparam int unsigned StoreDepth = 1 << TokenBits;
  localparam logic [15:0] CountMax   = 16'hFFFF;

  typedef struct packed {
    logic [15:0] total_tokens;
    logic [15:0] distinct_tokens;
    logic [15:0] top_count;
    logic [15:0] longest_run;
    logic        no_tokens;
    logic        low_unique;
    logic        high_freq;
    logic        long_run;
    logic        all_ok;
  } status_report_t;

  logic [15:0]          token_tally [StoreDepth];
  logic [15:0]          total_q;
  logic [15:0]          distinct_q;
  logic [15:0]          top_q;
  logic [15:0]          run_q;
  logic [15:0]          best_run_q;
  logic [TokenBits-1:0] last_token_q;
  trm_cfg_t             thresholds;
  status_report_t       expected_reports [$];
  status_report_t       want_r;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == CountMax) ? v : v + 16'd1;
  endfunction

  task automatic restart_stats();
    for (int unsigned i = 0; i < StoreDepth; i++) token_tally[i] = '0;
    total_q      = '0;
    distinct_q   = '0;
    top_q        = '0;
    run_q        = '0;
    best_run_q   = '0;
    last_token_q = '0;
  endtask

  task automatic count_token(input logic [TokenBits-1:0] tok);
    logic [15:0] c;
    c = token_tally[tok];
    if (c == '0) distinct_q = bump(distinct_q);
    c = bump(c);
    token_tally[tok] = c;
    if (c > top_q) top_q = c;
    if (total_q != '0 && tok == last_token_q) run_q = bump(run_q);
    else run_q = 16'd1;
    if (run_q > best_run_q) best_run_q = run_q;
    last_token_q = tok;
    total_q = bump(total_q);
  endtask

  function automatic status_report_t predict_report();
    status_report_t r;
    logic [63:0]    held;
    logic [63:0]    bound;
    r = '0;
    r.total_tokens    = total_q;
    r.distinct_tokens = distinct_q;
    r.top_count       = top_q;
    r.longest_run     = best_run_q;
    r.no_tokens       = (total_q == '0);
    if (total_q >= thresholds.min_tokens_for_checks) begin
      if (thresholds.min_unique_ratio != '0) begin
        if (r.no_tokens) begin
          r.low_unique = (thresholds.min_unique_ratio > ONE_Q16);
        end else begin
          held  = {32'd0, distinct_q, 16'd0};
          bound = 64'(thresholds.min_unique_ratio);
          bound = bound * 64'(total_q);
          r.low_unique = (held < bound);
        end
      end
      if (thresholds.top_ratio_max < ONE_Q16 && !r.no_tokens) begin
        held  = {32'd0, top_q, 16'd0};
        bound = 64'(thresholds.top_ratio_max);
        bound = bound * 64'(total_q);
        r.high_freq = (held > bound);
      end
      if (thresholds.max_run_limit != '0) r.long_run = (best_run_q > thresholds.max_run_limit);
    end
    r.all_ok = !(r.no_tokens || r.low_unique || r.high_freq || r.long_run);
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_stats();
      thresholds.min_unique_ratio      = '0;
      thresholds.top_ratio_max         = MAX_FREQ_RESET;
      thresholds.max_run_limit         = '0;
      thresholds.min_tokens_for_checks = MIN_TOKENS_RESET;
      expected_reports.delete();
      mismatches_o = 0;
      outstanding_o <= 0;
    end else begin
      // results first, so a report accepted at this edge cannot mask a stray result
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_reports.size() == 0) begin
          $error("report result arrived with no request pending");
          mismatches_o++;
        end else begin
          want_r = expected_reports.pop_front();
          compare_field("total_tokens", 32'(want_r.total_tokens), 32'(rsp_mon.total_tokens));
          compare_field("distinct_tokens", 32'(want_r.distinct_tokens),
                        32'(rsp_mon.distinct_tokens));
          compare_field("top_count", 32'(want_r.top_count), 32'(rsp_mon.top_count));
          compare_field("longest_run", 32'(want_r.longest_run), 32'(rsp_mon.longest_run));
          compare_field("no_tokens", 32'(want_r.no_tokens), 32'(rsp_mon.no_tokens));
          compare_field("low_unique", 32'(want_r.low_unique), 32'(rsp_mon.low_unique));
          compare_field("high_freq", 32'(want_r.high_freq), 32'(rsp_mon.high_freq));
          compare_field("long_run", 32'(want_r.long_run), 32'(rsp_mon.long_run));
          compare_field("all_ok", 32'(want_r.all_ok), 32'(rsp_mon.all_ok));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_UNIQUE: thresholds.min_unique_ratio = cfg_data_i;
          CFG_MAX_FREQ:   thresholds.top_ratio_max = cfg_data_i;
          CFG_MAX_RUN:    thresholds.max_run_limit = cfg_data_i[15:0];
          CFG_MIN_TOKENS: thresholds.min_tokens_for_checks = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.cmd)
          CMD_PUSH:   count_token(req_mon.token_id);
          CMD_REPORT: expected_reports.insert(expected_reports.size(), predict_report());
          CMD_CLEAR:  restart_stats();
          default: ;
        endcase
      end
      outstanding_o <= unsigned'(expected_reports.size());
    end
  end

endmodule
`default_nettype wire

### verif/tb.sv
// Testbench top for the token repetition monitor: stimulus, flow control and verdict.
`default_nettype none
module tb;
  import trm_pkg::*;

  localparam int          TokenBits  = 17;
  localparam int unsigned StallLimit = 4 * (1 << TokenBits);
  localparam logic [1:0]  CmdUnused  = 2'd3;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   cfg_we   = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx  = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  int unsigned            outstanding;
  int unsigned            mismatches;
  int unsigned            gap_max      = 16;
  int unsigned            stall_max    = 16;
  int unsigned            quiet_cycles = 0;
  int                     clears_left  = 1;
  logic [TokenBits-1:0]   last_tok     = '0;

  trm_in_if #(.TOKEN_BITS(TokenBits)) req_if ();
  trm_out_if                          rsp_if ();

  token_repetition_monitor_top #(
    .TOKEN_BITS(TokenBits),
    .COUNT_BITS(16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  trm_stats_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_if),
    .rsp_mon       (rsp_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned stall;
    rsp_if.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // valid is left high after accept; the next request lowers it only if it idles first
  task automatic send_request(input logic [1:0] cmd, input logic [TokenBits-1:0] tok);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.cmd      <= cmd;
    req_if.token_id <= tok;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic push_token(input logic [TokenBits-1:0] tok);
    send_request(CMD_PUSH, tok);
    last_tok = tok;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_thresholds(input logic [16:0] min_unique, input logic [16:0] peak_cap,
                                 input logic [16:0] max_run, input logic [16:0] min_tokens);
    logic [1:0] spare;
    spare    = 2'($urandom);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MIN_UNIQUE;
    cfg_data <= min_unique;
    @(posedge clk_i);
    cfg_idx  <= CFG_MAX_FREQ;
    cfg_data <= peak_cap;
    @(posedge clk_i);
    cfg_idx  <= CFG_MAX_RUN;
    cfg_data <= {spare[0], max_run[15:0]};
    @(posedge clk_i);
    cfg_idx  <= CFG_MIN_TOKENS;
    cfg_data <= {spare[1], min_tokens[15:0]};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [16:0] pick_setting(input logic [16:0] a, input logic [16:0] b,
                                               input logic [16:0] c, input int unsigned lo,
                                               input int unsigned hi);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return a;
      1: return b;
      2: return c;
      default: return 17'($urandom_range(lo, hi));
    endcase
  endfunction

  // mostly repeats and a small pool at both ends of the id range, some fully random ids
  function automatic logic [TokenBits-1:0] pick_token(input logic [TokenBits-1:0] prev);
    logic [TokenBits-1:0] tok;
    int unsigned          sel;
    sel = $urandom_range(0, 99);
    tok = 17'($urandom);
    if (sel < 35) tok = prev;
    else if (sel < 85) tok = tok[2] ? (tok | 17'h1FFFC) : (tok & 17'h00003);
    return tok;
  endfunction

  initial begin : stimulus
    int unsigned sel;
    req_if.valid    = 1'b0;
    req_if.cmd      = CMD_PUSH;
    req_if.token_id = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds, too few tokens for the ratio checks
    send_request(CMD_REPORT, 17'h15555);
    push_token(17'h1FFFF);
    push_token(17'h1FFFF);
    push_token(17'h00000);
    send_request(CMD_REPORT, 17'h0AAAA);
    wait_idle();

    // every check armed and at its strictest, empty stream after a clear
    load_thresholds(17'd131071, 17'd0, 17'd1, 17'd0);
    send_request(CMD_REPORT, 17'h00000);
    send_request(CMD_CLEAR, 17'h1FFFF);
    send_request(CMD_REPORT, 17'h00000);
    push_token(17'h00000);
    push_token(17'h00000);
    push_token(17'h00005);
    send_request(CmdUnused, 17'h1FFFF);
    send_request(CMD_REPORT, 17'h00000);
    push_token(17'h00005);
    push_token(17'h00005);
    push_token(17'h00005);
    send_request(CMD_REPORT, 17'h00000);
    wait_idle();

    // checks gated off by the token minimum
    load_thresholds(17'd65536, 17'd65535, 17'd65535, 17'd65535);
    send_request(CMD_REPORT, 17'h00000);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      gap_max   = (phase == 2) ? 0 : 16;
      stall_max = (phase == 3) ? 0 : 16;
      load_thresholds(pick_setting(17'd0, 17'd65536, 17'd131071, 1, 8192),
                      pick_setting(17'd0, 17'd65536, 17'd131071, 8192, 65535),
                      pick_setting(17'd0, 17'd1, 17'd65535, 1, 8),
                      pick_setting(17'd0, 17'd16, 17'd65535, 0, 40));
      for (int n = 0; n < 88; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          push_token(pick_token(last_tok));
        end else if (sel < 93) begin
          send_request(CMD_REPORT, 17'($urandom));
        end else if (sel < 97 || clears_left == 0) begin
          send_request(CmdUnused, 17'($urandom));
        end else begin
          send_request(CMD_CLEAR, 17'($urandom));
          clears_left--;
        end
      end
      send_request(CMD_REPORT, 17'($urandom));
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
